/* src/dpsm_pkg.sv */
// ----------------------------------------------------------------------------
// Demand-paged sparse memory package
// Shared word types, status codes and sequencer states for the paged memory.
// ----------------------------------------------------------------------------
package dpsm_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned WORD_BYTES = 4;
   localparam int unsigned WORD_BITS  = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNALIGNED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE   = 2'd2;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
      logic                newly_mapped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_ACCESS,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

endpackage

/* src/demand_paged_sparse_memory_top.sv */
// ----------------------------------------------------------------------------
// Demand-paged sparse memory, top level
// Maps full 32-bit word addresses onto a small backing store, page by page.
// ----------------------------------------------------------------------------
// The block takes one access word at a time and answers each with exactly one
// result word. After reset it first runs a clearing pass that writes zero to
// every backing word, one word a cycle, and stalls requests until the pass is
// done. The single tag comparator walks the tag RAM one slot at a time, with a
// registered read followed by a compare for each slot. A hit, or a miss that
// maps a new page, goes on to the access; an aligned read that reaches the
// backing store passes a further read-wait state, and a miss that finds every
// page in use goes straight to the result. The block goes back to idle on the
// edge that offers the result, so the next request is taken in the following
// cycle at the earliest. Physical pages are handed out in order from 0, on
// reads as well as writes, and are never freed. MEM_BYTES and PAGE_BYTES must
// be powers of two with MEM_BYTES not below PAGE_BYTES. A finished result sits
// in an output register, so the block returns to idle and takes the next
// request while the result waits; a further result waits in the sequencer
// until that register has been emptied.
// ----------------------------------------------------------------------------
module demand_paged_sparse_memory_top
   import dpsm_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = 4096,
   parameter int unsigned MEM_BYTES  = 65536
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Derived geometry.
   localparam int unsigned PAGE_BITS      = $clog2(PAGE_BYTES);
   localparam int unsigned TAG_W          = ADDR_W - PAGE_BITS;
   localparam int unsigned SLOTS          = MEM_BYTES / PAGE_BYTES;
   localparam int unsigned SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W          = $clog2(SLOTS + 1);
   localparam int unsigned MEM_WORDS      = MEM_BYTES / WORD_BYTES;
   localparam int unsigned WIDX_W         = $clog2(MEM_WORDS);
   localparam int unsigned PAGE_WORD_BITS = PAGE_BITS - WORD_BITS;

   // Sequencer and control registers.
   state_type         state_ff, state_in;
   logic [WIDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  pages_ff, pages_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   req_type             req_ff, req_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                fresh_ff, fresh_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic              tag_we;
   logic [SLOT_W-1:0] tag_wa;
   logic [SLOT_W-1:0] tag_ra;
   logic [TAG_W-1:0]  tag_rd;
   logic              mem_we;
   logic [WIDX_W-1:0] mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic [WIDX_W-1:0] mem_ra;
   logic [DATA_W-1:0] mem_rd;

   // Decoded request fields.
   logic [TAG_W-1:0]  req_tag;
   logic [WIDX_W-1:0] widx;
   logic              unaligned;
   logic              scan_end;
   logic              pages_full;
   logic              tag_hit;
   logic              rsp_load;

   assign req_tag    = req_ff.address[ADDR_W-1:PAGE_BITS];
   assign unaligned  = (req_ff.address[WORD_BITS-1:0] != '0);
   assign widx       = (WIDX_W'(slot_ff) << PAGE_WORD_BITS)
                     | WIDX_W'(req_ff.address[PAGE_BITS-1:0] >> WORD_BITS);
   assign scan_end   = (scan_ff == pages_ff);
   assign pages_full = (pages_ff == CNT_W'(SLOTS));
   assign tag_hit    = (tag_rd == req_tag);
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Tag store: slot k holds the page number mapped to physical page k. Only
   // slots below the fill count are ever compared, so it needs no clearing.
   dpsm_ram #(
      .WIDTH (TAG_W),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (req_tag),
      .rd_addr (tag_ra),
      .rd_data (tag_rd)
   );

   // Backing store of words, cleared by the pass after reset.
   dpsm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == WIDX_W'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            // Every mapped slot has been compared without a hit.
            if (scan_end) begin
               state_in = pages_full ? ST_RESP : ST_ACCESS;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            state_in = tag_hit ? ST_ACCESS : ST_SCAN_RD;
         end
         ST_ACCESS: begin
            if (!unaligned && (req_ff.op != OP_WRITE)) begin
               state_in = ST_READ_WAIT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      clr_in    = clr_ff;
      pages_in  = pages_ff;
      scan_in   = scan_ff;
      req_in    = req_ff;
      slot_in   = slot_ff;
      fresh_in  = fresh_ff;
      status_in = status_ff;
      rdata_in  = rdata_ff;
      tag_we    = 1'b0;
      tag_wa    = pages_ff[SLOT_W-1:0];
      tag_ra    = scan_ff[SLOT_W-1:0];
      mem_we    = 1'b0;
      mem_wa    = widx;
      mem_wd    = req_ff.write_data;
      mem_ra    = widx;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               scan_in   = '0;
               fresh_in  = 1'b0;
               status_in = STATUS_DONE;
               rdata_in  = '0;
            end
         end
         ST_SCAN_RD: begin
            if (scan_end) begin
               if (pages_full) begin
                  status_in = STATUS_NO_PAGE;
               end else begin
                  // Miss: take the next free physical page.
                  tag_we   = 1'b1;
                  slot_in  = pages_ff[SLOT_W-1:0];
                  pages_in = pages_ff + 1'b1;
                  fresh_in = 1'b1;
               end
            end
         end
         ST_SCAN_CMP: begin
            if (tag_hit) begin
               slot_in = scan_ff[SLOT_W-1:0];
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_ACCESS: begin
            if (unaligned) begin
               status_in = STATUS_UNALIGNED;
            end else if (req_ff.op == OP_WRITE) begin
               mem_we = 1'b1;
            end
         end
         ST_READ_WAIT: begin
            rdata_in = mem_rd;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.read_data    = rdata_ff;
         rsp_data_in.status       = status_ff;
         rsp_data_in.newly_mapped = fresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pages_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pages_ff     <= pages_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      slot_ff     <= slot_in;
      fresh_ff    <= fresh_in;
      status_ff   <= status_in;
      rdata_ff    <= rdata_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/dpsm_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dpsm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/paged_memory_checker.sv */
// ----------------------------------------------------------------------------
// Paged memory checker
// Watches both channels of the paged memory, works out the result word of
// every accepted request and compares it with what the block returns.
// ----------------------------------------------------------------------------
module paged_memory_checker
   import dpsm_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = 4096,
   parameter int unsigned MEM_BYTES  = 65536
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      words_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAGE_SLOTS     = MEM_BYTES / PAGE_BYTES;
   localparam int unsigned MEM_WORDS      = MEM_BYTES / WORD_BYTES;
   localparam int unsigned WORDS_PER_PAGE = PAGE_BYTES / WORD_BYTES;

   logic [ADDR_W-1:0] page_tag [PAGE_SLOTS];
   logic [DATA_W-1:0] backing  [MEM_WORDS];
   int unsigned       pages_used;
   rsp_type           awaited_results [$];
   int                error_count;

   // Looks the page up, maps it on a miss while slots remain, then moves
   // the data word when the offset is word aligned.
   function automatic rsp_type serve_access(req_type acc);
      rsp_type           res;
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] offset;
      int                slot;
      int unsigned       word_index;
      res    = '0;
      page   = acc.address / PAGE_BYTES;
      offset = acc.address % PAGE_BYTES;
      slot   = -1;
      for (int k = 0; k < pages_used; k++) begin
         if (slot < 0 && page_tag[k] == page) begin
            slot = k;
         end
      end
      if (slot < 0) begin
         if (pages_used >= PAGE_SLOTS) begin
            res.status = STATUS_NO_PAGE;
         end else begin
            slot             = pages_used;
            page_tag[slot]   = page;
            pages_used       = pages_used + 1;
            res.newly_mapped = 1'b1;
         end
      end
      if (res.status == STATUS_DONE) begin
         word_index = slot * WORDS_PER_PAGE + offset / WORD_BYTES;
         if ((offset % WORD_BYTES) != 0 || word_index >= MEM_WORDS) begin
            res.status = STATUS_UNALIGNED;
         end else if (acc.op == OP_WRITE) begin
            backing[word_index] = acc.write_data;
         end else begin
            res.read_data = backing[word_index];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_results.delete();
         pages_used = 0;
         foreach (page_tag[i]) page_tag[i] = '0;
         foreach (backing[i]) backing[i] = '0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(serve_access(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  error_count++;
                  $display("%0t: read_data expected %h, got %h",
                           $time, want.read_data, rsp_data.read_data);
               end
               if (rsp_data.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.newly_mapped !== want.newly_mapped) begin
                  error_count++;
                  $display("%0t: newly_mapped expected %b, got %b",
                           $time, want.newly_mapped, rsp_data.newly_mapped);
               end
            end
         end
      end
      mismatches    <= error_count;
      words_pending <= awaited_results.size();
   end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Paged memory testbench
// Drives directed and random word accesses into the paged memory with random
// idling on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
   import dpsm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAGE_BYTES  = 4096;
   localparam int unsigned MEM_BYTES   = 65536;
   localparam int unsigned PAGE_SLOTS  = MEM_BYTES / PAGE_BYTES;
   localparam int unsigned PAGE_NUM_W  = ADDR_W - $clog2(PAGE_BYTES);
   localparam int          RANDOM_WORDS = 924;
   // The limit covers the clearing pass, a full tag scan on every access with
   // all slots in use and the random idling on each side per word, so the
   // slowest correct run stays well below this.
   localparam int          CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatches;
   int      words_pending;
   int      cycle_count = 0;

   // When set, neither side idles; the stimulus flips it phase by phase so
   // that long runs at full rate alternate with runs full of gaps.
   bit      brisk = 1'b0;

   // Page numbers that the directed part has mapped; the random part mostly
   // aims at these so that reads find data written earlier.
   logic [PAGE_NUM_W-1:0] mapped_pages [$];

   demand_paged_sparse_memory_top #(
      .PAGE_BYTES (PAGE_BYTES),
      .MEM_BYTES  (MEM_BYTES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   paged_memory_checker #(
      .PAGE_BYTES (PAGE_BYTES),
      .MEM_BYTES  (MEM_BYTES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A hung block must not keep the run going for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The result side. Before each result word it may hold stall high for a
   // random gap, then lowers it until a word has been taken.
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         gap = brisk ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   function automatic bit page_is_mapped(logic [PAGE_NUM_W-1:0] page);
      foreach (mapped_pages[i]) begin
         if (mapped_pages[i] == page) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Draws a page number that is not in the list of mapped pages.
   function automatic logic [PAGE_NUM_W-1:0] fresh_page();
      logic [31:0]           draw;
      logic [PAGE_NUM_W-1:0] page;
      do begin
         draw = $urandom;
         page = draw[PAGE_NUM_W-1:0];
      end while (page_is_mapped(page));
      return page;
   endfunction

   function automatic logic [ADDR_W-1:0] page_address(logic [PAGE_NUM_W-1:0] page,
                                                      int unsigned offset);
      return ADDR_W'(page) * PAGE_BYTES + offset;
   endfunction

   // Offers one request word, after a random gap unless the phase is brisk,
   // and returns once the block has taken it. Valid stays high across
   // back-to-back words so the edge that accepts one word carries the next.
   task automatic issue(logic op, logic [ADDR_W-1:0] address,
                        logic [DATA_W-1:0] write_data);
      int gap;
      gap = brisk ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, address: address, write_data: write_data};
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      logic [PAGE_NUM_W-1:0] page;
      logic [31:0]           draw;
      int unsigned           offset;
      logic [DATA_W-1:0]     data;
      int                    pick;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A read of a fresh page maps it and finds the cleared
      // store; the top and bottom words of the address space, the last word
      // of a page, and all-ones and all-zeros data come next.
      issue(OP_READ,  32'h0000_0000, 32'h0000_0000);
      issue(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
      issue(OP_READ,  32'h0000_0000, 32'h0000_0000);
      issue(OP_WRITE, 32'hFFFF_FFFC, 32'hA5A5_A5A5);
      issue(OP_READ,  32'hFFFF_FFFC, 32'hFFFF_FFFF);
      // Unaligned read on a mapped page: the page hits but no data moves.
      issue(OP_READ,  32'hFFFF_FFFF, 32'h0000_0000);
      // Unaligned write on a fresh page still maps it; the read that
      // follows shows that nothing was stored.
      issue(OP_WRITE, 32'h8000_0002, 32'h5A5A_5A5A);
      issue(OP_READ,  32'h8000_0000, 32'h0000_0000);
      issue(OP_WRITE, 32'h0000_0FFC, 32'h1234_5678);
      issue(OP_READ,  32'h0000_0FFC, 32'h0000_0000);
      issue(OP_WRITE, 32'h0000_0FFC, 32'h0000_0000);
      issue(OP_READ,  32'h0000_0FFC, 32'hFFFF_FFFF);
      mapped_pages.push_back('0);
      mapped_pages.push_back('1);
      mapped_pages.push_back({1'b1, {(PAGE_NUM_W-1){1'b0}}});

      // Fill the remaining physical pages with fresh page numbers, every
      // fourth access unaligned.
      while (mapped_pages.size() < PAGE_SLOTS) begin
         page   = fresh_page();
         offset = $urandom_range(0, PAGE_BYTES - 1) & ~(WORD_BYTES - 1);
         if (mapped_pages.size() % 4 == 3) begin
            offset = offset | 3;
         end
         issue(mapped_pages.size() % 2 ? OP_WRITE : OP_READ,
               page_address(page, offset), $urandom);
         mapped_pages.push_back(page);
      end

      // Every page is now in use: a miss is dropped, read or write, aligned
      // or not.
      issue(OP_READ,  page_address(fresh_page(), 0), 32'h0000_0000);
      issue(OP_WRITE, page_address(fresh_page(), 1), 32'hFFFF_FFFF);
      issue(OP_WRITE, page_address(fresh_page(), 8), 32'hC3C3_C3C3);

      // Random part. Most accesses go to mapped pages and to a few offsets
      // near either end of a page, so that reads return data written
      // before; the rest hit random addresses, mostly unmapped pages.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 80 == 0) begin
            brisk = (((n / 80) % 2) != 0);
         end

         // Once, the sender stops until the block has answered everything.
         if (n == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (words_pending != 0) @(posedge clock);
         end

         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
         end else begin
            draw = $urandom;
            page = draw[PAGE_NUM_W-1:0];
         end

         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            offset = $urandom_range(0, 7) * WORD_BYTES;
         end else if (pick < 75) begin
            offset = PAGE_BYTES - $urandom_range(1, 8) * WORD_BYTES;
         end else if (pick < 90) begin
            offset = $urandom_range(0, PAGE_BYTES - 1) & ~(WORD_BYTES - 1);
         end else begin
            offset = $urandom_range(0, PAGE_BYTES - 1);
         end

         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            data = '1;
         end else if (pick == 1) begin
            data = '0;
         end else begin
            data = $urandom;
         end

         issue($urandom_range(0, 1) ? OP_WRITE : OP_READ,
               page_address(page, offset), data);
      end

      // Drain: wait for every outstanding result word, then give the block
      // a little longer in case it sends something it should not.
      brisk = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
